// File: sv/dnhr_pkg.sv
package dnhr_pkg;

  localparam int NodeCountDef = 16;
  localparam int MaxDegreeDef = 8;

  localparam int NODE_W   = 4;
  localparam int STATUS_W = 3;

  localparam logic OP_LINK  = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SAME    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNREACH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0]   next_hop;
    logic [STATUS_W-1:0] status;
  } out_t;

endpackage

// File: sv/dfs_next_hop_router.sv
// Next-hop router over an undirected link table of small node indices.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one item per
// transfer: operation 0 adds the link node_a--node_b, operation 1 asks for
// the next hop on a depth-first path from node_a to node_b. Every item
// gives exactly one result on the output channel (out_valid_o /
// out_stall_i / out_data_o) with next_hop and status.
// One item is worked on at a time by a single sequencer that reuses one
// list-scan compare unit against the neighbour memory; in_stall_o is high
// from acceptance until the result is loaded into the output register.
// The time for a link grows with len_a + len_b, len being the length of
// each end's neighbour list. A route that a check answers needs no search;
// else its time grows with each search step, each neighbour entry examined
// and each backtrack, and the rescans of the lists at every step set the
// worst case.
// Reset clears the known marks, the visited marks and the path depth; a
// list count reads as zero until its node is known, and the neighbour and
// path memories need no clearing.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile, but its result waits until the register is free.
module dfs_next_hop_router #(
  parameter int NODE_COUNT = dnhr_pkg::NodeCountDef,
  parameter int MAX_DEGREE = dnhr_pkg::MaxDegreeDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dnhr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dnhr_pkg::out_t out_data_o
);

  localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int DW  = $clog2(NODE_COUNT + 1);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int AW  = $clog2(NODE_COUNT * MAX_DEGREE);
  localparam int NbrDepth = NODE_COUNT * MAX_DEGREE;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DISP  = 11'b000_0000_0010,
    S_CNT   = 11'b000_0000_0100,
    S_CLOAD = 11'b000_0000_1000,
    S_SCAN  = 11'b000_0001_0000,
    S_SCMP  = 11'b000_0010_0000,
    S_POP   = 11'b000_0100_0000,
    S_ADEC  = 11'b000_1000_0000,
    S_WA    = 11'b001_0000_0000,
    S_WB    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    PH_A   = 2'd0,
    PH_B   = 2'd1,
    PH_DFS = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q;

  dnhr_pkg::in_t  in_q;
  dnhr_pkg::out_t out_data_q;
  logic           out_valid_q;

  logic [NODE_COUNT-1:0] known_q;
  logic [NODE_COUNT-1:0] visited_q;
  logic [DW-1:0]         depth_q;

  logic [NIW-1:0] own_q, tgt_q, hop_q;
  logic [CW-1:0]  cnt_q, cnt_a_q, cnt_b_q, slot_q;
  logic           need_a_q, need_b_q;

  logic [dnhr_pkg::NODE_W-1:0]   res_hop_q;
  logic [dnhr_pkg::STATUS_W-1:0] res_st_q;

  logic [CW-1:0]  cnt_mem [NODE_COUNT];
  logic [NIW-1:0] nbr_mem [NbrDepth];
  logic [NIW-1:0] stk_mem [NODE_COUNT];
  logic [CW-1:0]  cnt_rd_q;
  logic [NIW-1:0] nbr_rd_q, stk_rd_q;

  logic [NIW-1:0] a_idx, b_idx;
  logic           range_ok, route_bad, same_ab;
  logic [CW-1:0]  cnt_eff;
  logic           hit, scan_end, full, out_free, route_go;

  logic           cnt_we, nbr_we, stk_we;
  logic [NIW-1:0] cnt_waddr, stk_waddr, stk_raddr, nbr_wdata, stk_wdata;
  logic [CW-1:0]  cnt_wdata;
  logic [AW-1:0]  nbr_waddr, nbr_raddr;
  logic [DW-1:0]  depth_m2;

  assign a_idx    = NIW'(in_q.node_a);
  assign b_idx    = NIW'(in_q.node_b);
  assign same_ab  = (a_idx == b_idx);
  assign range_ok = (32'(in_q.node_a) < NODE_COUNT) && (32'(in_q.node_b) < NODE_COUNT);
  assign route_bad = !known_q[a_idx] || !known_q[b_idx] || same_ab;
  assign route_go = (state_q == S_DISP) && range_ok &&
                    (in_q.operation == dnhr_pkg::OP_ROUTE) && !route_bad;
  assign cnt_eff  = known_q[own_q] ? cnt_rd_q : '0;
  assign hit      = (phase_q == PH_DFS) ? !visited_q[nbr_rd_q] : (nbr_rd_q == tgt_q);
  assign scan_end = (slot_q == cnt_q);
  assign full     = (need_a_q && (cnt_a_q == CW'(MAX_DEGREE))) ||
                    (need_b_q && (cnt_b_q == CW'(MAX_DEGREE)));
  assign out_free = !out_valid_q || !out_stall_i;

  assign cnt_we    = ((state_q == S_WA) && need_a_q) || ((state_q == S_WB) && need_b_q);
  assign nbr_we    = cnt_we;
  assign cnt_waddr = (state_q == S_WA) ? a_idx : b_idx;
  assign cnt_wdata = ((state_q == S_WA) ? cnt_a_q : cnt_b_q) + CW'(1);
  assign nbr_waddr = (state_q == S_WA) ?
                     AW'(AW'(a_idx) * AW'(MAX_DEGREE) + AW'(cnt_a_q)) :
                     AW'(AW'(b_idx) * AW'(MAX_DEGREE) + AW'(cnt_b_q));
  assign nbr_wdata = (state_q == S_WA) ? b_idx : a_idx;
  assign nbr_raddr = AW'(AW'(own_q) * AW'(MAX_DEGREE) + AW'(slot_q));

  assign stk_we    = route_go || ((state_q == S_SCMP) && (phase_q == PH_DFS) && hit);
  assign stk_waddr = (state_q == S_DISP) ? '0 : depth_q[NIW-1:0];
  assign stk_wdata = (state_q == S_DISP) ? a_idx : nbr_rd_q;
  assign depth_m2  = depth_q - DW'(2);
  assign stk_raddr = depth_m2[NIW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        if (!range_ok) state_d = S_DONE;
        else if (in_q.operation == dnhr_pkg::OP_LINK) state_d = S_CNT;
        else if (route_bad) state_d = S_DONE;
        else state_d = S_CNT;
      end
      S_CNT:   state_d = S_CLOAD;
      S_CLOAD: state_d = S_SCAN;
      S_SCAN: begin
        if (!scan_end) state_d = S_SCMP;
        else begin
          unique case (phase_q)
            PH_A:    state_d = same_ab ? S_ADEC : S_CNT;
            PH_B:    state_d = S_ADEC;
            PH_DFS:  state_d = (depth_q == DW'(1)) ? S_DONE : S_POP;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCMP: begin
        if (!hit) state_d = S_SCAN;
        else begin
          unique case (phase_q)
            PH_A:    state_d = same_ab ? S_ADEC : S_CNT;
            PH_B:    state_d = S_ADEC;
            PH_DFS:  state_d = (nbr_rd_q == b_idx) ? S_DONE : S_CNT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP:  state_d = S_CNT;
      S_ADEC: state_d = full ? S_DONE : S_WA;
      S_WA:   state_d = S_WB;
      S_WB:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      known_q     <= '0;
      visited_q   <= '0;
      depth_q     <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (route_go) begin
        visited_q <= NODE_COUNT'(1) << a_idx;
        depth_q   <= DW'(1);
      end
      if ((state_q == S_SCMP) && (phase_q == PH_DFS) && hit) begin
        visited_q[nbr_rd_q] <= 1'b1;
        depth_q             <= depth_q + DW'(1);
      end
      if ((state_q == S_SCAN) && (phase_q == PH_DFS) && scan_end) begin
        depth_q <= depth_q - DW'(1);
      end
      if (state_q == S_WA) begin
        known_q[a_idx] <= 1'b1;
        known_q[b_idx] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) in_q <= in_data_i;
      end
      S_DISP: begin
        res_hop_q <= '0;
        need_a_q  <= 1'b0;
        need_b_q  <= 1'b0;
        own_q     <= a_idx;
        tgt_q     <= b_idx;
        if (!range_ok) res_st_q <= dnhr_pkg::ST_UNKNOWN;
        else if (in_q.operation == dnhr_pkg::OP_LINK) phase_q <= PH_A;
        else if (!known_q[a_idx] || !known_q[b_idx]) res_st_q <= dnhr_pkg::ST_UNKNOWN;
        else if (same_ab) res_st_q <= dnhr_pkg::ST_SAME;
        else phase_q <= PH_DFS;
      end
      S_CLOAD: begin
        cnt_q  <= cnt_eff;
        slot_q <= '0;
        if (phase_q == PH_A) cnt_a_q <= cnt_eff;
        if (phase_q == PH_B) cnt_b_q <= cnt_eff;
      end
      S_SCAN: begin
        if (scan_end) begin
          unique case (phase_q)
            PH_A: begin
              need_a_q <= 1'b1;
              own_q    <= b_idx;
              tgt_q    <= a_idx;
              phase_q  <= PH_B;
            end
            PH_B:    need_b_q <= 1'b1;
            PH_DFS:  res_st_q <= dnhr_pkg::ST_UNREACH;
            default: res_st_q <= dnhr_pkg::ST_UNKNOWN;
          endcase
        end
      end
      S_SCMP: begin
        if (!hit) slot_q <= slot_q + CW'(1);
        else begin
          unique case (phase_q)
            PH_A: begin
              need_a_q <= 1'b0;
              own_q    <= b_idx;
              tgt_q    <= a_idx;
              phase_q  <= PH_B;
            end
            PH_B: need_b_q <= 1'b0;
            PH_DFS: begin
              own_q <= nbr_rd_q;
              if (depth_q == DW'(1)) hop_q <= nbr_rd_q;
              if (nbr_rd_q == b_idx) begin
                res_st_q  <= dnhr_pkg::ST_FOUND;
                res_hop_q <= dnhr_pkg::NODE_W'((depth_q == DW'(1)) ? nbr_rd_q : hop_q);
              end
            end
            default: res_st_q <= dnhr_pkg::ST_UNKNOWN;
          endcase
        end
      end
      S_POP: own_q <= stk_rd_q;
      S_ADEC: begin
        if (full) res_st_q <= dnhr_pkg::ST_FULL;
      end
      S_WB: res_st_q <= dnhr_pkg::ST_ADDED;
      S_DONE: begin
        if (out_free) begin
          out_data_q.next_hop <= res_hop_q;
          out_data_q.status   <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[own_q];
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
    nbr_rd_q <= nbr_mem[nbr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/dnhr_checker.sv
module dnhr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dnhr_pkg::out_t out_data_o
);

  // hold off further input once a transfer has been taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item in progress");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed under stall");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= dnhr_pkg::ST_FULL)
    else $error("status code out of range");

  a_hop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != dnhr_pkg::ST_FOUND) |->
      (out_data_o.next_hop == '0))
    else $error("next hop set without a route");

endmodule

bind dfs_next_hop_router dnhr_checker u_dnhr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: tb/tb.sv
module tb;

  localparam int NODE_W       = dnhr_pkg::NODE_W;
  localparam int STATUS_W     = dnhr_pkg::STATUS_W;
  localparam int IN_W         = $bits(dnhr_pkg::in_t);
  localparam int NODES        = dnhr_pkg::NodeCountDef;
  localparam int DEGREE       = dnhr_pkg::MaxDegreeDef;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASE_ITEMS  = 175;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ISLAND_LO    = 11;
  localparam int ISLAND_HI    = 14;

  class hop_scoreboard;
    bit                known [NODES];
    int unsigned       degree_of [NODES];
    logic [NODE_W-1:0] adjacency [NODES][DEGREE];
    dnhr_pkg::out_t    expected_hops [$];
    int                errors;

    function bit listed(logic [NODE_W-1:0] owner, logic [NODE_W-1:0] who);
      int i;
      for (i = 0; i < degree_of[owner]; i++) begin
        if (adjacency[owner][i] == who) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [STATUS_W-1:0] add_link(logic [NODE_W-1:0] a,
                                           logic [NODE_W-1:0] b);
      bit need_a;
      bit need_b;
      need_a = !listed(a, b);
      need_b = (a != b) && !listed(b, a);
      if ((need_a && degree_of[a] >= DEGREE) || (need_b && degree_of[b] >= DEGREE)) begin
        return dnhr_pkg::ST_FULL;
      end
      known[a] = 1'b1;
      known[b] = 1'b1;
      if (need_a) begin
        adjacency[a][degree_of[a]] = b;
        degree_of[a]++;
      end
      if (need_b) begin
        adjacency[b][degree_of[b]] = a;
        degree_of[b]++;
      end
      return dnhr_pkg::ST_ADDED;
    endfunction

    function logic [STATUS_W-1:0] search(logic [NODE_W-1:0] s, logic [NODE_W-1:0] d,
                                         output logic [NODE_W-1:0] hop);
      bit                seen [NODES];
      logic [NODE_W-1:0] stack [NODES];
      logic [NODE_W-1:0] top;
      logic [NODE_W-1:0] nb;
      int                depth;
      int                i;
      bit                pushed;
      hop = '0;
      if (!known[s] || !known[d]) return dnhr_pkg::ST_UNKNOWN;
      if (s == d) return dnhr_pkg::ST_SAME;
      foreach (seen[n]) seen[n] = 1'b0;
      stack[0] = s;
      depth    = 1;
      seen[s]  = 1'b1;
      while (depth > 0) begin
        top    = stack[depth-1];
        pushed = 1'b0;
        for (i = 0; i < degree_of[top] && !pushed; i++) begin
          nb = adjacency[top][i];
          if (!seen[nb]) begin
            seen[nb]     = 1'b1;
            stack[depth] = nb;
            depth++;
            pushed = 1'b1;
          end
        end
        if (!pushed) begin
          depth--;
        end else if (stack[depth-1] == d) begin
          hop = stack[1];
          return dnhr_pkg::ST_FOUND;
        end
      end
      return dnhr_pkg::ST_UNREACH;
    endfunction

    function void note_transfer(dnhr_pkg::in_t item);
      dnhr_pkg::out_t    want;
      logic [NODE_W-1:0] hop;
      want = '0;
      if (item.operation == dnhr_pkg::OP_LINK) begin
        want.status = add_link(item.node_a, item.node_b);
      end else begin
        want.status   = search(item.node_a, item.node_b, hop);
        want.next_hop = hop;
      end
      expected_hops.insert(expected_hops.size(), want);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(dnhr_pkg::out_t got);
      dnhr_pkg::out_t want;
      if (expected_hops.size() == 0) begin
        report($sformatf("result with nothing outstanding: hop %0d status %0d",
                         got.next_hop, got.status));
        return;
      end
      want = expected_hops.pop_front();
      if (got.next_hop !== want.next_hop) begin
        report($sformatf("next_hop %0d, want %0d", got.next_hop, want.next_hop));
      end
      if (got.status !== want.status) begin
        report($sformatf("status %0d, want %0d", got.status, want.status));
      end
    endtask
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  dnhr_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  dnhr_pkg::out_t out_data_o;
  int unsigned    idle_pct    = 0;
  int unsigned    stall_pct   = 0;
  int unsigned    cycles      = 0;
  hop_scoreboard  hops        = new();

  dfs_next_hop_router i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    forever begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) hops.check_result(out_data_o);
    end
  end

  function automatic dnhr_pkg::in_t make_item(logic op, int a, int b);
    dnhr_pkg::in_t item;
    item.operation = op;
    item.node_a    = a[NODE_W-1:0];
    item.node_b    = b[NODE_W-1:0];
    return item;
  endfunction

  function automatic logic [NODE_W-1:0] pick_node(bit island);
    int v;
    if (island) return NODE_W'($urandom_range(ISLAND_HI, ISLAND_LO));
    v = $urandom_range(ISLAND_LO);
    return (v == ISLAND_LO) ? NODE_W'(NODES - 1) : NODE_W'(v);
  endfunction

  // Link items stay inside two separate groups until the merge stage, but for raw random items.
  function automatic dnhr_pkg::in_t random_item(bit merge);
    dnhr_pkg::in_t item;
    int            roll;
    bit            island;
    roll           = $urandom_range(99);
    item.operation = dnhr_pkg::OP_ROUTE;
    item.node_a    = NODE_W'($urandom_range(NODES - 1));
    item.node_b    = NODE_W'($urandom_range(NODES - 1));
    if (roll < 5) begin
      item = dnhr_pkg::in_t'(IN_W'($urandom_range((1 << IN_W) - 1)));
    end else if (roll < 35) begin
      item.operation = dnhr_pkg::OP_LINK;
      if (!merge) begin
        island      = ($urandom_range(3) == 0);
        item.node_a = pick_node(island);
        item.node_b = pick_node(island);
      end
    end else if (roll < 45) begin
      item.node_b = item.node_a;
    end
    return item;
  endfunction

  task automatic send(dnhr_pkg::in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    hops.note_transfer(item);
  endtask

  initial begin
    int fan [8];
    int k;
    fan = '{1, 3, 4, 6, 7, 8, 9, 10};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(make_item(dnhr_pkg::OP_ROUTE, 0, 15));
    send(make_item(dnhr_pkg::OP_ROUTE, 3, 3));
    send(make_item(dnhr_pkg::OP_LINK, 5, 5));
    send(make_item(dnhr_pkg::OP_ROUTE, 5, 5));
    send(make_item(dnhr_pkg::OP_LINK, 5, 5));
    send(make_item(dnhr_pkg::OP_LINK, 0, 15));
    send(make_item(dnhr_pkg::OP_LINK, 15, 0));
    send(make_item(dnhr_pkg::OP_ROUTE, 0, 15));
    send(make_item(dnhr_pkg::OP_ROUTE, 15, 5));
    foreach (fan[i]) send(make_item(dnhr_pkg::OP_LINK, 2, fan[i]));
    send(make_item(dnhr_pkg::OP_LINK, 11, 2));
    send(make_item(dnhr_pkg::OP_ROUTE, 11, 2));
    send(make_item(dnhr_pkg::OP_ROUTE, 1, 10));
    send(make_item(dnhr_pkg::OP_LINK, 10, 15));
    send(make_item(dnhr_pkg::OP_ROUTE, 1, 0));
    send(make_item(dnhr_pkg::OP_ROUTE, 15, 1));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_ITEMS == 0) begin
        case ((k / PHASE_ITEMS) % 4)
          0: begin
            idle_pct  = 0;
            stall_pct = 0;
          end
          1: begin
            idle_pct  = 86;
            stall_pct = 0;
          end
          2: begin
            idle_pct  = 0;
            stall_pct = 86;
          end
          default: begin
            idle_pct  = 17;
            stall_pct = 17;
          end
        endcase
      end
      send(random_item(k >= RANDOM_ITEMS * 85 / 100));
    end
    in_valid_i <= 1'b0;

    while (hops.expected_hops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (hops.errors == 0 && hops.expected_hops.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
sv/dnhr_pkg.sv
sv/dfs_next_hop_router.sv
sv/dnhr_checker.sv
tb/tb.sv
